>>> rtl/src_pkg.sv
package src_pkg;

  localparam int unsigned FREQ_W  = 31;
  localparam int unsigned REQ_W   = 32;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned PROD_W  = IDX_W + FREQ_W;

  localparam logic [FREQ_W-1:0] BAND_MIN_RST = FREQ_W'(100000);
  localparam logic [FREQ_W-1:0] BAND_MAX_RST = FREQ_W'(1500000000);
  localparam logic [IDX_W-1:0]  POINTS_RST   = IDX_W'(101);
  localparam logic [FREQ_W-1:0] EDGE_A_RST   = FREQ_W'(500000);
  localparam logic [FREQ_W-1:0] EDGE_B_RST   = FREQ_W'(10500000);

  typedef enum logic [MODE_W-1:0] {
    MODE_START  = 3'd0,
    MODE_STOP   = 3'd1,
    MODE_CENTER = 3'd2,
    MODE_SPAN   = 3'd3,
    MODE_CW     = 3'd4,
    MODE_QUERY  = 3'd5
  } mode_e;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_BAND_MIN    = 2'd0,
    CFG_BAND_MAX    = 2'd1,
    CFG_POINT_COUNT = 2'd2
  } cfg_addr_e;

  // One request to the shared adder; sub selects x - y instead of x + y.
  typedef struct packed {
    logic              sub;
    logic [PROD_W-1:0] x;
    logic [PROD_W-1:0] y;
  } alu_req_t;

  typedef struct packed {
    logic              valid;
    logic [FREQ_W-1:0] edge_a;
    logic [FREQ_W-1:0] edge_b;
    logic [FREQ_W-1:0] point_freq;
    logic              point_valid;
  } src_res_t;

endpackage

>>> rtl/src_alu.sv
module src_alu (
  input  src_pkg::alu_req_t        req_i,
  output logic [src_pkg::PROD_W:0] res_o
);
  import src_pkg::*;

  logic [PROD_W-1:0] y_eff;

  // For a subtraction the top bit is the carry out: set when x >= y.
  assign y_eff = req_i.sub ? ~req_i.y : req_i.y;
  assign res_o = {1'b0, req_i.x} + {1'b0, y_eff} + {{PROD_W{1'b0}}, req_i.sub};

endmodule

>>> rtl/src_seq.sv
module src_seq #(
  parameter int unsigned MAX_POINTS = 101
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [src_pkg::MODE_W-1:0]  mode_i,
  input  logic [src_pkg::REQ_W-1:0]   freq_i,
  input  logic [src_pkg::IDX_W-1:0]   index_i,
  input  logic [src_pkg::FREQ_W-1:0]  band_lo_i,
  input  logic [src_pkg::FREQ_W-1:0]  band_hi_i,
  input  logic [src_pkg::IDX_W-1:0]   point_count_i,
  input  logic                        res_take_i,
  output logic                        idle_o,
  output src_pkg::src_res_t           res_o
);
  import src_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ORDER, S_CLO, S_CHI, S_SET,
    S_CEN_SUM, S_CEN_CMP, S_CEN_SPAN, S_CEN_LOH, S_CEN_LOCMP, S_CEN_LOFIX,
    S_CEN_HIH, S_CEN_HICMP, S_CEN_HIFIX, S_CEN_EA, S_CEN_EB,
    S_SPN_DIFF, S_SPN_CMP, S_SPN_SUM, S_SPN_LOH, S_SPN_LOCMP, S_SPN_HIH,
    S_SPN_HICMP, S_SPN_HIFIX, S_SPN_EB, S_SPN_EA,
    S_Q_DIFF, S_Q_MUL, S_Q_DIV, S_Q_ADD, S_DONE
  } state_e;

  localparam int unsigned CNT_W = $clog2(PROD_W);

  state_e              state_q, state_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [REQ_W-1:0]    f_q, f_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [FREQ_W-1:0]   ea_q, ea_d, eb_q, eb_d;
  logic [FREQ_W-1:0]   h_q, h_d;
  logic [REQ_W-1:0]    c_q, c_d;
  logic [PROD_W-1:0]   p_q, p_d;
  logic [IDX_W-1:0]    r_q, r_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [FREQ_W-1:0]   pf_q, pf_d;
  logic                pv_q, pv_d;

  alu_req_t            alu_req;
  logic [PROD_W:0]     alu_res;
  logic                alu_lt, alu_eq, alu_gt;
  logic [IDX_W-1:0]    n_eff;
  logic [IDX_W-1:0]    divisor;
  logic [IDX_W:0]      rem_cand;
  logic [REQ_W-1:0]    half;

  src_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  assign alu_lt = ~alu_res[PROD_W];
  assign alu_eq = (alu_res[PROD_W-1:0] == '0);
  assign alu_gt = ~alu_lt & ~alu_eq;

  assign n_eff    = (32'(point_count_i) > MAX_POINTS) ? IDX_W'(MAX_POINTS) : point_count_i;
  assign divisor  = n_eff - IDX_W'(1);
  assign rem_cand = {r_q, p_q[PROD_W-1]};
  assign half     = {1'b0, f_q[REQ_W-1:1]};

  assign idle_o            = (state_q == S_IDLE);
  assign res_o.valid       = (state_q == S_DONE);
  assign res_o.edge_a      = ea_q;
  assign res_o.edge_b      = eb_q;
  assign res_o.point_freq  = pf_q;
  assign res_o.point_valid = pv_q;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    f_d     = f_q;
    idx_d   = idx_q;
    ea_d    = ea_q;
    eb_d    = eb_q;
    h_d     = h_q;
    c_d     = c_q;
    p_d     = p_q;
    r_d     = r_q;
    cnt_d   = cnt_q;
    pf_d    = pf_q;
    pv_d    = pv_q;
    alu_req = '{sub: 1'b0, x: '0, y: '0};

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          mode_d  = mode_i;
          f_d     = freq_i;
          idx_d   = index_i;
          state_d = S_ORDER;
        end
      end

      S_ORDER: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(ea_q), y: PROD_W'(eb_q)};
        pf_d = '0;
        pv_d = 1'b0;
        unique case (mode_q)
          MODE_START, MODE_STOP: begin
            if (alu_gt) begin
              ea_d = eb_q;
              eb_d = ea_q;
            end
            state_d = S_CLO;
          end
          MODE_CENTER, MODE_SPAN: begin
            if (!alu_gt) begin
              ea_d = eb_q;
              eb_d = ea_q;
            end
            state_d = (mode_q == MODE_SPAN) ? S_CHI : S_CLO;
          end
          MODE_CW: state_d = S_CLO;
          MODE_QUERY: begin
            // h holds the lower edge and c the upper one.
            h_d = alu_lt ? ea_q : eb_q;
            c_d = REQ_W'(alu_lt ? eb_q : ea_q);
            state_d = (idx_q < n_eff) ? S_Q_DIFF : S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end

      S_CLO: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(f_q), y: PROD_W'(band_lo_i)};
        if (alu_lt) f_d = REQ_W'(band_lo_i);
        state_d = S_CHI;
      end

      S_CHI: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(f_q), y: PROD_W'(band_hi_i)};
        if (alu_gt) f_d = REQ_W'(band_hi_i);
        if (mode_q == MODE_CENTER) state_d = S_CEN_SUM;
        else if (mode_q == MODE_SPAN) state_d = S_SPN_DIFF;
        else state_d = S_SET;
      end

      S_SET: begin
        state_d = S_DONE;
        if (mode_q == MODE_START) begin
          alu_req = '{sub: 1'b1, x: PROD_W'(eb_q), y: PROD_W'(f_q)};
          ea_d = f_q[FREQ_W-1:0];
          if (alu_lt) eb_d = f_q[FREQ_W-1:0];
        end else if (mode_q == MODE_STOP) begin
          alu_req = '{sub: 1'b1, x: PROD_W'(ea_q), y: PROD_W'(f_q)};
          eb_d = f_q[FREQ_W-1:0];
          if (alu_gt) ea_d = f_q[FREQ_W-1:0];
        end else begin
          ea_d = f_q[FREQ_W-1:0];
          eb_d = f_q[FREQ_W-1:0];
        end
      end

      // Center: keep the half span in h, shrink it to fit the band.
      S_CEN_SUM: begin
        alu_req = '{sub: 1'b0, x: PROD_W'(ea_q >> 1), y: PROD_W'(eb_q >> 1)};
        c_d = alu_res[REQ_W-1:0];
        state_d = S_CEN_CMP;
      end
      S_CEN_CMP: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(c_q), y: PROD_W'(f_q)};
        state_d = alu_eq ? S_DONE : S_CEN_SPAN;
      end
      S_CEN_SPAN: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(ea_q), y: PROD_W'(eb_q)};
        h_d = {1'b0, alu_res[FREQ_W-1:1]};
        state_d = S_CEN_LOH;
      end
      S_CEN_LOH: begin
        alu_req = '{sub: 1'b0, x: PROD_W'(band_lo_i), y: PROD_W'(h_q)};
        c_d = alu_res[REQ_W-1:0];
        state_d = S_CEN_LOCMP;
      end
      S_CEN_LOCMP: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(f_q), y: PROD_W'(c_q)};
        state_d = alu_lt ? S_CEN_LOFIX : S_CEN_HIH;
      end
      S_CEN_LOFIX: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(f_q), y: PROD_W'(band_lo_i)};
        h_d = alu_res[FREQ_W-1:0];
        state_d = S_CEN_HIH;
      end
      S_CEN_HIH: begin
        alu_req = '{sub: 1'b0, x: PROD_W'(f_q), y: PROD_W'(h_q)};
        c_d = alu_res[REQ_W-1:0];
        state_d = S_CEN_HICMP;
      end
      S_CEN_HICMP: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(c_q), y: PROD_W'(band_hi_i)};
        state_d = alu_gt ? S_CEN_HIFIX : S_CEN_EA;
      end
      S_CEN_HIFIX: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(band_hi_i), y: PROD_W'(f_q)};
        h_d = alu_res[FREQ_W-1:0];
        state_d = S_CEN_EA;
      end
      S_CEN_EA: begin
        alu_req = '{sub: 1'b0, x: PROD_W'(f_q), y: PROD_W'(h_q)};
        ea_d = alu_res[FREQ_W-1:0];
        state_d = S_CEN_EB;
      end
      S_CEN_EB: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(f_q), y: PROD_W'(h_q)};
        eb_d = alu_res[FREQ_W-1:0];
        state_d = S_DONE;
      end

      // Span: c holds the center, p serves as a scratch register.
      S_SPN_DIFF: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(ea_q), y: PROD_W'(eb_q)};
        c_d = alu_res[REQ_W-1:0];
        state_d = S_SPN_CMP;
      end
      S_SPN_CMP: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(c_q), y: PROD_W'(f_q)};
        state_d = alu_eq ? S_DONE : S_SPN_SUM;
      end
      S_SPN_SUM: begin
        alu_req = '{sub: 1'b0, x: PROD_W'(ea_q >> 1), y: PROD_W'(eb_q >> 1)};
        c_d = alu_res[REQ_W-1:0];
        state_d = S_SPN_LOH;
      end
      S_SPN_LOH: begin
        alu_req = '{sub: 1'b0, x: PROD_W'(band_lo_i), y: PROD_W'(half)};
        p_d = alu_res[PROD_W-1:0];
        state_d = S_SPN_LOCMP;
      end
      S_SPN_LOCMP: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(c_q), y: p_q};
        if (alu_lt) c_d = p_q[REQ_W-1:0];
        state_d = S_SPN_HIH;
      end
      S_SPN_HIH: begin
        alu_req = '{sub: 1'b0, x: PROD_W'(c_q), y: PROD_W'(half)};
        p_d = alu_res[PROD_W-1:0];
        state_d = S_SPN_HICMP;
      end
      S_SPN_HICMP: begin
        alu_req = '{sub: 1'b1, x: p_q, y: PROD_W'(band_hi_i)};
        state_d = alu_gt ? S_SPN_HIFIX : S_SPN_EB;
      end
      S_SPN_HIFIX: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(band_hi_i), y: PROD_W'(half)};
        c_d = alu_res[REQ_W-1:0];
        state_d = S_SPN_EB;
      end
      S_SPN_EB: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(c_q), y: PROD_W'(half)};
        eb_d = alu_res[FREQ_W-1:0];
        state_d = S_SPN_EA;
      end
      S_SPN_EA: begin
        alu_req = '{sub: 1'b0, x: PROD_W'(c_q), y: PROD_W'(half)};
        ea_d = alu_res[FREQ_W-1:0];
        state_d = S_DONE;
      end

      S_Q_DIFF: begin
        alu_req = '{sub: 1'b1, x: PROD_W'(c_q), y: PROD_W'(h_q)};
        c_d   = alu_res[REQ_W-1:0];
        p_d   = '0;
        cnt_d = '0;
        // With a single point only index 0 is valid and it sits on the low edge.
        state_d = (n_eff < IDX_W'(2)) ? S_Q_ADD : S_Q_MUL;
      end
      S_Q_MUL: begin
        // Shift-and-add product, index bits taken from the top down.
        alu_req = '{sub: 1'b0, x: {p_q[PROD_W-2:0], 1'b0},
                    y: idx_q[IDX_W-1] ? PROD_W'(c_q) : '0};
        p_d   = alu_res[PROD_W-1:0];
        idx_d = {idx_q[IDX_W-2:0], 1'b0};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(IDX_W - 1)) begin
          cnt_d   = '0;
          r_d     = '0;
          state_d = S_Q_DIV;
        end
      end
      S_Q_DIV: begin
        // Restoring division, one quotient bit per cycle shifted into p.
        alu_req = '{sub: 1'b1, x: PROD_W'(rem_cand), y: PROD_W'(divisor)};
        r_d   = alu_lt ? rem_cand[IDX_W-1:0] : alu_res[IDX_W-1:0];
        p_d   = {p_q[PROD_W-2:0], ~alu_lt};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(PROD_W - 1)) state_d = S_Q_ADD;
      end
      S_Q_ADD: begin
        alu_req = '{sub: 1'b0, x: PROD_W'(h_q), y: p_q};
        pf_d    = alu_res[FREQ_W-1:0];
        pv_d    = 1'b1;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_take_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= '0;
      f_q     <= '0;
      idx_q   <= '0;
      ea_q    <= EDGE_A_RST;
      eb_q    <= EDGE_B_RST;
      h_q     <= '0;
      c_q     <= '0;
      p_q     <= '0;
      r_q     <= '0;
      cnt_q   <= '0;
      pf_q    <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      f_q     <= f_d;
      idx_q   <= idx_d;
      ea_q    <= ea_d;
      eb_q    <= eb_d;
      h_q     <= h_d;
      c_q     <= c_d;
      p_q     <= p_d;
      r_q     <= r_d;
      cnt_q   <= cnt_d;
      pf_q    <= pf_d;
      pv_q    <= pv_d;
    end
  end

endmodule

>>> rtl/sweep_range_controller.sv
// Channel   Direction  Handshake                    Payload
// in        input      in_valid_i / in_ready_o      mode_i, freq_value_i, point_index_i
// out       output     out_valid_o / out_ready_i    edge_a_o, edge_b_o, point_freq_o,
//                                                   point_valid_o
// cfg       input      cfg_we_i (no wait)           cfg_addr_i, cfg_wdata_i
//
// One transaction at a time runs through a sequencer around a single shared adder.
// A point query runs 7 shift-add multiply steps, then 38 restoring division steps.
// Reset loads the band registers, the point count and both edges; no clearing pass.
// A finished result sits in the output register, so the next transaction is accepted
// while it waits; the sequencer stalls only when that register is still occupied.
module sweep_range_controller #(
  parameter int unsigned MAX_POINTS = 101
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [src_pkg::MODE_W-1:0]    mode_i,
  input  logic [src_pkg::REQ_W-1:0]     freq_value_i,
  input  logic [src_pkg::IDX_W-1:0]     point_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [src_pkg::FREQ_W-1:0]    edge_a_o,
  output logic [src_pkg::FREQ_W-1:0]    edge_b_o,
  output logic [src_pkg::FREQ_W-1:0]    point_freq_o,
  output logic                          point_valid_o,
  input  logic                          cfg_we_i,
  input  logic [src_pkg::CFG_A_W-1:0]   cfg_addr_i,
  input  logic [src_pkg::FREQ_W-1:0]    cfg_wdata_i
);
  import src_pkg::*;

  logic [FREQ_W-1:0] band_min_q, band_min_d;
  logic [FREQ_W-1:0] band_max_q, band_max_d;
  logic [FREQ_W-1:0] band_hi_q, band_hi_d;
  logic [IDX_W-1:0]  points_q, points_d;
  logic              out_valid_q;
  logic              out_free;
  logic              seq_idle;
  src_res_t          seq_res;
  logic [FREQ_W-1:0] edge_a_q, edge_b_q, point_freq_q;
  logic              point_valid_q;

  always_comb begin
    band_min_d = band_min_q;
    band_max_d = band_max_q;
    points_d   = points_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_BAND_MIN:    band_min_d = cfg_wdata_i;
        CFG_BAND_MAX:    band_max_d = cfg_wdata_i;
        CFG_POINT_COUNT: points_d   = cfg_wdata_i[IDX_W-1:0];
        default: ;
      endcase
    end
    // An inverted band collapses the upper limit onto band_min.
    band_hi_d = (band_max_d < band_min_d) ? band_min_d : band_max_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_min_q <= BAND_MIN_RST;
      band_max_q <= BAND_MAX_RST;
      band_hi_q  <= BAND_MAX_RST;
      points_q   <= POINTS_RST;
    end else begin
      band_min_q <= band_min_d;
      band_max_q <= band_max_d;
      band_hi_q  <= band_hi_d;
      points_q   <= points_d;
    end
  end

  assign out_free   = ~out_valid_q | out_ready_i;
  assign in_ready_o = seq_idle;

  src_seq #(
    .MAX_POINTS (MAX_POINTS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_valid_i),
    .mode_i        (mode_i),
    .freq_i        (freq_value_i),
    .index_i       (point_index_i),
    .band_lo_i     (band_min_q),
    .band_hi_i     (band_hi_q),
    .point_count_i (points_q),
    .res_take_i    (out_free),
    .idle_o        (seq_idle),
    .res_o         (seq_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_res.valid && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res.valid && out_free) begin
      edge_a_q      <= seq_res.edge_a;
      edge_b_q      <= seq_res.edge_b;
      point_freq_q  <= seq_res.point_freq;
      point_valid_q <= seq_res.point_valid;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign edge_a_o      = edge_a_q;
  assign edge_b_o      = edge_b_q;
  assign point_freq_o  = point_freq_q;
  assign point_valid_o = point_valid_q;

endmodule

>>> tb/sv/sweep_checker.sv
module sweep_checker
  import src_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 101
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [MODE_W-1:0]    mode_i,
  input  logic [REQ_W-1:0]     freq_value_i,
  input  logic [IDX_W-1:0]     point_index_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [FREQ_W-1:0]    edge_a_i,
  input  logic [FREQ_W-1:0]    edge_b_i,
  input  logic [FREQ_W-1:0]    point_freq_i,
  input  logic                 point_valid_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_A_W-1:0]   cfg_addr_i,
  input  logic [FREQ_W-1:0]    cfg_wdata_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [FREQ_W-1:0] edge_a;
    logic [FREQ_W-1:0] edge_b;
    logic [FREQ_W-1:0] point_freq;
    logic              point_valid;
  } sweep_answer_t;

  // Local copy of the sweep state and the configuration registers.
  logic [FREQ_W-1:0] band_min_q;
  logic [FREQ_W-1:0] band_max_q;
  logic [IDX_W-1:0]  points_q;
  logic [FREQ_W-1:0] edge_a_q;
  logic [FREQ_W-1:0] edge_b_q;

  sweep_answer_t sweep_answers_q[$];
  sweep_answer_t want;
  sweep_answer_t got;
  int unsigned   fails;
  int unsigned   taken_n;
  int unsigned   given_n;

  assign fail_count_o = fails;
  assign pending_o    = taken_n - given_n;

  function automatic longint fit_band(input longint f, input longint lo, input longint hi);
    if (f < lo) f = lo;
    if (f > hi) f = hi;
    return f;
  endfunction

  // Applies one transaction to the edges and works out the answer it produces.
  function automatic sweep_answer_t predict_sweep(input logic [MODE_W-1:0] mode,
                                                  input logic [REQ_W-1:0]  freq,
                                                  input logic [IDX_W-1:0]  idx);
    longint lo, hi, f, a, b, t, mid, span, half, n, ix, low_e, high_e, pf;
    sweep_answer_t ans;
    lo  = longint'(band_min_q);
    hi  = (band_max_q < band_min_q) ? longint'(band_min_q) : longint'(band_max_q);
    f   = longint'(freq);
    ix  = longint'(idx);
    a   = longint'(edge_a_q);
    b   = longint'(edge_b_q);
    pf  = 0;
    ans = '0;
    case (mode)
      MODE_START, MODE_STOP: begin
        if (a > b) begin
          t = a; a = b; b = t;
        end
        f = fit_band(f, lo, hi);
        if (mode == MODE_START) begin
          a = f;
          if (b < f) b = f;
        end else begin
          b = f;
          if (a > f) a = f;
        end
      end
      MODE_CENTER: begin
        f = fit_band(f, lo, hi);
        if (a <= b) begin
          t = a; a = b; b = t;
        end
        mid = a / 2 + b / 2;
        if (mid != f) begin
          span = a - b;
          if (f < lo + span / 2) span = (f - lo) * 2;
          if (f > hi - span / 2) span = (hi - f) * 2;
          a = f + span / 2;
          b = f - span / 2;
        end
      end
      MODE_SPAN: begin
        // The span is only limited from above, never by the low band edge.
        if (f > hi) f = hi;
        if (a <= b) begin
          t = a; a = b; b = t;
        end
        if (a - b != f) begin
          half = f / 2;
          mid  = a / 2 + b / 2;
          if (mid < lo + half) mid = lo + half;
          if (mid > hi - half) mid = hi - half;
          b = mid - half;
          a = mid + half;
        end
      end
      MODE_CW: begin
        f = fit_band(f, lo, hi);
        a = f;
        b = f;
      end
      MODE_QUERY: begin
        n = longint'(points_q);
        if (n > MAX_POINTS) n = MAX_POINTS;
        if (ix < n) begin
          low_e  = (a < b) ? a : b;
          high_e = (a < b) ? b : a;
          pf = low_e;
          if (n >= 2) pf = low_e + (ix * (high_e - low_e)) / (n - 1);
          ans.point_valid = 1'b1;
        end
      end
      default: ;
    endcase
    ans.edge_a     = a[FREQ_W-1:0];
    ans.edge_b     = b[FREQ_W-1:0];
    ans.point_freq = pf[FREQ_W-1:0];
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_min_q = BAND_MIN_RST;
      band_max_q = BAND_MAX_RST;
      points_q   = POINTS_RST;
      edge_a_q   = EDGE_A_RST;
      edge_b_q   = EDGE_B_RST;
      sweep_answers_q.delete();
      fails   = 0;
      taken_n <= 0;
      given_n <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{edge_a_i, edge_b_i, point_freq_i, point_valid_i};
        if (sweep_answers_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with no transaction outstanding: a=%0d b=%0d f=%0d v=%0b",
                     $time, got.edge_a, got.edge_b, got.point_freq, got.point_valid);
        end else begin
          want = sweep_answers_q.pop_front();
          given_n <= given_n + 1;
          if (got.edge_a != want.edge_a || got.edge_b != want.edge_b ||
              got.point_freq != want.point_freq || got.point_valid != want.point_valid) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch: expected a=%0d b=%0d f=%0d v=%0b, got a=%0d b=%0d f=%0d v=%0b",
                       $time, want.edge_a, want.edge_b, want.point_freq, want.point_valid,
                       got.edge_a, got.edge_b, got.point_freq, got.point_valid);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_BAND_MIN:    band_min_q = cfg_wdata_i;
          CFG_BAND_MAX:    band_max_q = cfg_wdata_i;
          CFG_POINT_COUNT: points_q   = cfg_wdata_i[IDX_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        want     = predict_sweep(mode_i, freq_value_i, point_index_i);
        edge_a_q = want.edge_a;
        edge_b_q = want.edge_b;
        sweep_answers_q.push_back(want);
        taken_n <= taken_n + 1;
      end
    end
  end

endmodule

>>> tb/sv/tb_sweep_range_controller.sv
module tb_sweep_range_controller;
  import src_pkg::*;

  localparam int unsigned SWEEP_POINTS    = 101;
  localparam int unsigned NUM_PHASES      = 11;
  localparam int unsigned ITEMS_PER_PHASE = 90;
  localparam int unsigned HOLD_PHASE      = 8;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned QUIET_LIMIT     = 5000;
  localparam int unsigned TAIL_CYCLES     = 64;

  localparam logic [MODE_W-1:0]  MODE_UNUSED_A = 3'd6;
  localparam logic [MODE_W-1:0]  MODE_UNUSED_B = 3'd7;
  localparam logic [CFG_A_W-1:0] CFG_SPARE     = 2'd3;
  localparam logic [FREQ_W-1:0]  FREQ_ALL_ONES = '1;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [MODE_W-1:0]   mode_i = '0;
  logic [REQ_W-1:0]    freq_value_i = '0;
  logic [IDX_W-1:0]    point_index_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [FREQ_W-1:0]   edge_a_o;
  logic [FREQ_W-1:0]   edge_b_o;
  logic [FREQ_W-1:0]   point_freq_o;
  logic                point_valid_o;
  logic                cfg_we_i = 1'b0;
  logic [CFG_A_W-1:0]  cfg_addr_i = '0;
  logic [FREQ_W-1:0]   cfg_wdata_i = '0;

  int unsigned fail_count;
  int unsigned pending;

  // Knobs for the two sides and the stimulus' copy of the band settings.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_given = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  longint      band_lo_w = 100000;
  longint      band_hi_w = 1500000000;
  int unsigned points_eff = SWEEP_POINTS;
  int unsigned n_queries = 0;
  int unsigned n_settings = 0;
  int unsigned n_unused = 0;

  always #5 clk_i = ~clk_i;

  sweep_range_controller #(
    .MAX_POINTS(SWEEP_POINTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .freq_value_i  (freq_value_i),
    .point_index_i (point_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .edge_a_o      (edge_a_o),
    .edge_b_o      (edge_b_o),
    .point_freq_o  (point_freq_o),
    .point_valid_o (point_valid_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  sweep_checker #(
    .MAX_POINTS(SWEEP_POINTS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .mode_i        (mode_i),
    .freq_value_i  (freq_value_i),
    .point_index_i (point_index_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .edge_a_i      (edge_a_o),
    .edge_b_i      (edge_b_o),
    .point_freq_i  (point_freq_o),
    .point_valid_i (point_valid_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_given  <= hold_given + 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("sweep_range_controller test failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [MODE_W-1:0] m, input logic [REQ_W-1:0] f,
                           input logic [IDX_W-1:0] ix);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    freq_value_i  <= f;
    point_index_i <= ix;
    do @(posedge clk_i); while (!in_ready_o);
    case (m)
      MODE_QUERY: n_queries++;
      MODE_START, MODE_STOP, MODE_CENTER, MODE_SPAN, MODE_CW: n_settings++;
      default: n_unused++;
    endcase
  endtask

  // Stops offering and waits until every outstanding transaction has answered.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [FREQ_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_band(input logic [FREQ_W-1:0] lo, input logic [FREQ_W-1:0] hi,
                          input logic [FREQ_W-1:0] pts);
    write_reg(CFG_BAND_MIN, lo);
    write_reg(CFG_BAND_MAX, hi);
    write_reg(CFG_POINT_COUNT, pts);
    cfg_we_i  <= 1'b0;
    band_lo_w = longint'(lo);
    band_hi_w = (hi < lo) ? longint'(lo) : longint'(hi);
    points_eff = (pts[IDX_W-1:0] > SWEEP_POINTS) ? SWEEP_POINTS : pts[IDX_W-1:0];
  endtask

  task automatic apply_phase(input int unsigned p);
    logic [FREQ_W-1:0] lo;
    case (p)
      1:  set_band('0, FREQ_ALL_ONES, 101);
      2:  set_band(1000, 5000, 2);
      3:  set_band(2000000000, 100, 127);   // inverted band, count beyond the limit
      4:  set_band(123456, 987654321, 1);
      5:  set_band('0, '0, 0);
      6: begin
        write_reg(CFG_SPARE, $urandom());
        set_band($urandom(), $urandom(), $urandom_range(0, 127));
      end
      7:  set_band(FREQ_ALL_ONES, FREQ_ALL_ONES, 50);
      8:  set_band(100000, 1500000000, 101);
      9:  set_band(50000000, 60000000, $urandom_range(2, 101));
      10: begin
        lo = $urandom_range(0, 1000000000);
        set_band(lo, lo + $urandom_range(0, 1000000000), $urandom_range(2, 101));
      end
      default: ;
    endcase
  endtask

  function automatic logic [REQ_W-1:0] pick_freq(input bit for_span);
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return $urandom();
      1: return '0;
      2: return '1;
      3: return for_span ? REQ_W'(0) : REQ_W'(band_lo_w);
      4: return REQ_W'(band_hi_w);
      5: return REQ_W'(band_lo_w) + REQ_W'($urandom_range(0, 3));
      default: begin
        if (for_span)
          return $urandom_range(REQ_W'(band_hi_w - band_lo_w), 0);
        return $urandom_range(REQ_W'(band_hi_w), REQ_W'(band_lo_w));
      end
    endcase
  endfunction

  task automatic send_random();
    int unsigned r;
    logic [IDX_W-1:0] ix;
    r  = $urandom_range(0, 99);
    ix = $urandom_range(0, 127);
    if (r < 38) begin
      if (points_eff > 0 && $urandom_range(0, 3) != 0)
        ix = $urandom_range(0, points_eff - 1);
      send_item(MODE_QUERY, $urandom(), ix);
    end else if (r < 49) send_item(MODE_START, pick_freq(1'b0), ix);
    else if (r < 60) send_item(MODE_STOP, pick_freq(1'b0), ix);
    else if (r < 71) send_item(MODE_CENTER, pick_freq(1'b0), ix);
    else if (r < 82) send_item(MODE_SPAN, pick_freq(1'b1), ix);
    else if (r < 93) send_item(MODE_CW, pick_freq(1'b0), ix);
    else send_item(r[0] ? MODE_UNUSED_A : MODE_UNUSED_B, $urandom(), ix);
  endtask

  initial begin
    int unsigned p;
    int unsigned i;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed transactions under the reset band.
    send_item(MODE_QUERY, '0, 0);
    send_item(MODE_QUERY, '0, 100);
    send_item(MODE_QUERY, '0, 101);
    send_item(MODE_QUERY, '1, 127);
    send_item(MODE_START, '0, 0);
    send_item(MODE_STOP, '1, 0);
    send_item(MODE_QUERY, '0, 50);
    send_item(MODE_CENTER, 750000000, 0);
    send_item(MODE_SPAN, '0, 0);
    send_item(MODE_QUERY, '0, 100);
    send_item(MODE_SPAN, '1, 0);
    send_item(MODE_CENTER, '0, 0);
    send_item(MODE_CW, '1, 0);
    send_item(MODE_QUERY, '0, 100);
    send_item(MODE_START, 1000000000, 0);
    send_item(MODE_STOP, 200000, 0);
    send_item(MODE_CENTER, 1499999999, 0);
    send_item(MODE_SPAN, 3000000, 0);
    send_item(MODE_UNUSED_A, '1, 127);
    send_item(MODE_UNUSED_B, '0, 0);
    send_item(MODE_QUERY, '0, 77);
    send_item(MODE_CW, '0, 0);
    send_item(MODE_SPAN, 1000, 0);
    send_item(MODE_QUERY, '0, 1);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      apply_phase(p);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      // The long hold-off lets the block fill up while input keeps coming.
      if (p == HOLD_PHASE) hold_asked = hold_asked + 1;
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == HOLD_PHASE && i == ITEMS_PER_PHASE / 2) drain();
        send_random();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("ran %0d transactions: %0d point queries, %0d setting commands, %0d unused modes",
             n_queries + n_settings + n_unused, n_queries, n_settings, n_unused);
    $display("over %0d register settings incl. inverted, empty and full-width bands", NUM_PHASES);
    if (fail_count == 0 && pending == 0) begin
      $display("sweep_range_controller test passed");
    end else begin
      $display("%0d failures, %0d results missing", fail_count, pending);
      $display("sweep_range_controller test failed");
    end
    $finish;
  end

endmodule
